@@ sv/lca_pkg.sv @@
// ----------------------------------------------------------------------------
// Lowest common ancestor package
// Shared widths, defaults, item codes and the sequencer state type.
// ----------------------------------------------------------------------------
package lca_pkg;

   localparam int NODE_W         = 10;
   localparam int DEPTH_W        = 10;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

   localparam int MAX_NODES_DEF  = 1024;
   localparam int LOG_LEVELS_DEF = 10;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR0,
      ST_ADD_RDJ,
      ST_ADD_WRJ,
      ST_Q_RDD,
      ST_Q_CMP,
      ST_Q_LRD,
      ST_Q_LWR,
      ST_Q_EQ,
      ST_Q_JRD,
      ST_Q_JWR,
      ST_Q_FRD,
      ST_Q_FIN
   } lca_state_type;

endpackage

@@ sv/lca_ram.sv @@
// ----------------------------------------------------------------------------
// LCA table memory
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module lca_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr0,
   input  logic [ADDR_W-1:0] rd_addr1,
   output logic [DATA_W-1:0] rd_data0,
   output logic [DATA_W-1:0] rd_data1
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end

endmodule

@@ sv/lca_core.sv @@
// ----------------------------------------------------------------------------
// LCA sequencer and datapath
// Steps through table builds and lifting searches, one table level at a time.
// ----------------------------------------------------------------------------
module lca_core #(
   parameter int MAX_NODES  = lca_pkg::MAX_NODES_DEF,
   parameter int LOG_LEVELS = lca_pkg::LOG_LEVELS_DEF,
   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
   localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  logic [lca_pkg::NODE_W-1:0]   req_node_a,
   input  logic [lca_pkg::NODE_W-1:0]   req_node_b,
   output logic                         rsp_valid,
   output logic [lca_pkg::NODE_W-1:0]   rsp_ancestor,
   // depth store
   output logic                         dep_we,
   output logic [AW-1:0]                dep_waddr,
   output logic [lca_pkg::DEPTH_W-1:0]  dep_wdata,
   output logic [AW-1:0]                dep_ra0,
   output logic [AW-1:0]                dep_ra1,
   input  logic [lca_pkg::DEPTH_W-1:0]  dep_rd0,
   input  logic [lca_pkg::DEPTH_W-1:0]  dep_rd1,
   // jump table
   output logic                         jmp_we,
   output logic [AW+LW-1:0]             jmp_waddr,
   output logic [lca_pkg::NODE_W-1:0]   jmp_wdata,
   output logic [AW+LW-1:0]             jmp_ra0,
   output logic [AW+LW-1:0]             jmp_ra1,
   input  logic [lca_pkg::NODE_W-1:0]   jmp_rd0,
   input  logic [lca_pkg::NODE_W-1:0]   jmp_rd1
);

   localparam int NW = lca_pkg::NODE_W;
   localparam int DW = lca_pkg::DEPTH_W;
   localparam logic [LW-1:0] LEV_TOP  = LW'(LOG_LEVELS - 1);
   localparam logic [LW-1:0] LEV_LAST = LW'(LOG_LEVELS - 2);

   function automatic logic [AW-1:0] to_addr(input logic [NW-1:0] n);
      logic [AW+NW-1:0] w;
      w = {{AW{1'b0}}, n};
      return w[AW-1:0];
   endfunction

   function automatic logic [NW-1:0] node_of(input logic [NW-1:0] n);
      return (32'(n) < 32'(MAX_NODES)) ? n : '0;
   endfunction

   lca_pkg::lca_state_type state_ff, state_in;

   logic [NW-1:0] u_ff, u_in, v_ff, v_in, cur_ff, cur_in;
   logic [AW-1:0] n_ff, n_in;
   logic [DW-1:0] diff_ff, diff_in;
   logic [LW-1:0] lev_ff, lev_in;
   logic          z0_ff, z1_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0] rsp_anc_ff, rsp_anc_in;

   logic [NW-1:0] rd_node0, rd_node1;
   logic [NW-1:0] na, nb, jq0, jq1;
   logic [DW-1:0] dq0, dq1;
   logic [DW:0]   dep_inc;
   logic [DW-1:0] diff_sh;
   logic          add_ok, lift_bit, lev_zero, lev_last, ju_ne;

   // node 0 is the sentinel: its entries always read as zero
   assign dq0 = z0_ff ? '0 : dep_rd0;
   assign dq1 = z1_ff ? '0 : dep_rd1;
   assign jq0 = z0_ff ? '0 : jmp_rd0;
   assign jq1 = z1_ff ? '0 : jmp_rd1;

   assign na       = node_of(req_node_a);
   assign nb       = node_of(req_node_b);
   assign add_ok   = (req_node_a != '0) && (32'(req_node_a) < 32'(MAX_NODES));
   assign dep_inc  = {1'b0, dq0} + {{DW{1'b0}}, 1'b1};
   assign diff_sh  = diff_ff >> lev_ff;
   assign lift_bit = diff_sh[0];
   assign lev_zero = (lev_ff == '0);
   assign lev_last = (lev_ff == LEV_LAST);
   assign ju_ne    = (jq0 != jq1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lca_pkg::ST_IDLE: begin
            if (start) begin
               if (req_kind == lca_pkg::KIND_ADD) begin
                  if (add_ok) state_in = lca_pkg::ST_ADD_RD;
               end else if (na != nb) begin
                  state_in = lca_pkg::ST_Q_RDD;
               end
            end
         end
         lca_pkg::ST_ADD_RD:  state_in = lca_pkg::ST_ADD_WR0;
         lca_pkg::ST_ADD_WR0: begin
            state_in = (LOG_LEVELS > 1) ? lca_pkg::ST_ADD_RDJ : lca_pkg::ST_IDLE;
         end
         lca_pkg::ST_ADD_RDJ: state_in = lca_pkg::ST_ADD_WRJ;
         lca_pkg::ST_ADD_WRJ: begin
            state_in = lev_last ? lca_pkg::ST_IDLE : lca_pkg::ST_ADD_RDJ;
         end
         lca_pkg::ST_Q_RDD: state_in = lca_pkg::ST_Q_CMP;
         lca_pkg::ST_Q_CMP: state_in = lca_pkg::ST_Q_LRD;
         lca_pkg::ST_Q_LRD: begin
            if (lift_bit)      state_in = lca_pkg::ST_Q_LWR;
            else if (lev_zero) state_in = lca_pkg::ST_Q_EQ;
         end
         lca_pkg::ST_Q_LWR: begin
            state_in = lev_zero ? lca_pkg::ST_Q_EQ : lca_pkg::ST_Q_LRD;
         end
         lca_pkg::ST_Q_EQ: begin
            state_in = (u_ff == v_ff) ? lca_pkg::ST_IDLE : lca_pkg::ST_Q_JRD;
         end
         lca_pkg::ST_Q_JRD: state_in = lca_pkg::ST_Q_JWR;
         lca_pkg::ST_Q_JWR: begin
            state_in = lev_zero ? lca_pkg::ST_Q_FRD : lca_pkg::ST_Q_JRD;
         end
         lca_pkg::ST_Q_FRD: state_in = lca_pkg::ST_Q_FIN;
         lca_pkg::ST_Q_FIN: state_in = lca_pkg::ST_IDLE;
         default:           state_in = lca_pkg::ST_IDLE;
      endcase
   end

   // memory controls and result
   always_comb begin
      dep_we       = 1'b0;
      dep_waddr    = n_ff;
      dep_wdata    = dep_inc[DW] ? lca_pkg::DEPTH_MAX : dep_inc[DW-1:0];
      dep_ra0      = to_addr(u_ff);
      dep_ra1      = to_addr(v_ff);
      jmp_we       = 1'b0;
      jmp_waddr    = {n_ff, lev_ff + LW'(1)};
      jmp_wdata    = jq0;
      jmp_ra0      = {to_addr(u_ff), lev_ff};
      jmp_ra1      = {to_addr(v_ff), lev_ff};
      rd_node0     = '0;
      rd_node1     = '0;
      rsp_valid_in = 1'b0;
      rsp_anc_in   = rsp_anc_ff;
      unique case (state_ff)
         lca_pkg::ST_IDLE: begin
            if (start && (req_kind == lca_pkg::KIND_QUERY) && (na == nb)) begin
               rsp_valid_in = 1'b1;
               rsp_anc_in   = na;
            end
         end
         lca_pkg::ST_ADD_RD: begin
            dep_ra0  = to_addr(cur_ff);
            rd_node0 = cur_ff;
         end
         lca_pkg::ST_ADD_WR0: begin
            dep_we    = 1'b1;
            jmp_we    = 1'b1;
            jmp_waddr = {n_ff, LW'(0)};
            jmp_wdata = cur_ff;
         end
         lca_pkg::ST_ADD_RDJ: begin
            jmp_ra0  = {to_addr(cur_ff), lev_ff};
            rd_node0 = cur_ff;
         end
         lca_pkg::ST_ADD_WRJ: jmp_we = 1'b1;
         lca_pkg::ST_Q_RDD: begin
            rd_node0 = u_ff;
            rd_node1 = v_ff;
         end
         lca_pkg::ST_Q_LRD: rd_node0 = u_ff;
         lca_pkg::ST_Q_EQ: begin
            if (u_ff == v_ff) begin
               rsp_valid_in = 1'b1;
               rsp_anc_in   = u_ff;
            end
         end
         lca_pkg::ST_Q_JRD: begin
            rd_node0 = u_ff;
            rd_node1 = v_ff;
         end
         lca_pkg::ST_Q_FRD: begin
            jmp_ra0  = {to_addr(u_ff), LW'(0)};
            rd_node0 = u_ff;
         end
         lca_pkg::ST_Q_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_anc_in   = jq0;
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      u_in    = u_ff;
      v_in    = v_ff;
      cur_in  = cur_ff;
      n_in    = n_ff;
      diff_in = diff_ff;
      lev_in  = lev_ff;
      unique case (state_ff)
         lca_pkg::ST_IDLE: begin
            n_in   = to_addr(req_node_a);
            cur_in = nb;
            u_in   = na;
            v_in   = nb;
         end
         lca_pkg::ST_ADD_WR0: lev_in = '0;
         lca_pkg::ST_ADD_WRJ: begin
            cur_in = jq0;
            lev_in = lev_ff + LW'(1);
         end
         lca_pkg::ST_Q_CMP: begin
            // deeper node goes to u
            if (dq0 < dq1) begin
               u_in    = v_ff;
               v_in    = u_ff;
               diff_in = dq1 - dq0;
            end else begin
               diff_in = dq0 - dq1;
            end
            lev_in = LEV_TOP;
         end
         lca_pkg::ST_Q_LRD: begin
            if (!lift_bit && !lev_zero) lev_in = lev_ff - LW'(1);
         end
         lca_pkg::ST_Q_LWR: begin
            u_in = jq0;
            if (!lev_zero) lev_in = lev_ff - LW'(1);
         end
         lca_pkg::ST_Q_EQ: lev_in = LEV_TOP;
         lca_pkg::ST_Q_JWR: begin
            if (ju_ne) begin
               u_in = jq0;
               v_in = jq1;
            end
            if (!lev_zero) lev_in = lev_ff - LW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lca_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff       <= u_in;
      v_ff       <= v_in;
      cur_ff     <= cur_in;
      n_ff       <= n_in;
      diff_ff    <= diff_in;
      lev_ff     <= lev_in;
      z0_ff      <= (rd_node0 == '0);
      z1_ff      <= (rd_node1 == '0);
      rsp_anc_ff <= rsp_anc_in;
   end

   assign busy         = (state_ff != lca_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_anc_ff;

endmodule

@@ sv/lowest_common_ancestor_unit.sv @@
// ----------------------------------------------------------------------------
// Lowest common ancestor unit, binary lifting
// Add words store depth and jump table; query words return the common ancestor.
// ----------------------------------------------------------------------------
// Add word: busy for one read and one write per table level. Query word:
// busy for two passes over the levels through the jump table ports, whose
// read data is registered; equal nodes answer at once. The result strobe is
// registered from the last step and is never stalled. Synchronous reset
// returns the sequencer to idle; tables are not cleared, node 0 always reads
// as zero.
module lowest_common_ancestor_unit #(
   parameter int MAX_NODES  = lca_pkg::MAX_NODES_DEF,
   parameter int LOG_LEVELS = lca_pkg::LOG_LEVELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_kind,
   input  logic [lca_pkg::NODE_W-1:0] req_node_a,
   input  logic [lca_pkg::NODE_W-1:0] req_node_b,
   output logic                       rsp_valid,
   output logic [lca_pkg::NODE_W-1:0] rsp_ancestor
);

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;

   logic                        dep_we, jmp_we;
   logic [AW-1:0]               dep_waddr, dep_ra0, dep_ra1;
   logic [lca_pkg::DEPTH_W-1:0] dep_wdata, dep_rd0, dep_rd1;
   logic [AW+LW-1:0]            jmp_waddr, jmp_ra0, jmp_ra1;
   logic [lca_pkg::NODE_W-1:0]  jmp_wdata, jmp_rd0, jmp_rd1;

   lca_core #(
      .MAX_NODES  (MAX_NODES),
      .LOG_LEVELS (LOG_LEVELS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_node_a   (req_node_a),
      .req_node_b   (req_node_b),
      .rsp_valid    (rsp_valid),
      .rsp_ancestor (rsp_ancestor),
      .dep_we       (dep_we),
      .dep_waddr    (dep_waddr),
      .dep_wdata    (dep_wdata),
      .dep_ra0      (dep_ra0),
      .dep_ra1      (dep_ra1),
      .dep_rd0      (dep_rd0),
      .dep_rd1      (dep_rd1),
      .jmp_we       (jmp_we),
      .jmp_waddr    (jmp_waddr),
      .jmp_wdata    (jmp_wdata),
      .jmp_ra0      (jmp_ra0),
      .jmp_ra1      (jmp_ra1),
      .jmp_rd0      (jmp_rd0),
      .jmp_rd1      (jmp_rd1)
   );

   lca_ram #(
      .ADDR_W (AW),
      .DATA_W (lca_pkg::DEPTH_W)
   ) u_depth (
      .clock    (clock),
      .wr_en    (dep_we),
      .wr_addr  (dep_waddr),
      .wr_data  (dep_wdata),
      .rd_addr0 (dep_ra0),
      .rd_addr1 (dep_ra1),
      .rd_data0 (dep_rd0),
      .rd_data1 (dep_rd1)
   );

   lca_ram #(
      .ADDR_W (AW + LW),
      .DATA_W (lca_pkg::NODE_W)
   ) u_jump (
      .clock    (clock),
      .wr_en    (jmp_we),
      .wr_addr  (jmp_waddr),
      .wr_data  (jmp_wdata),
      .rd_addr0 (jmp_ra0),
      .rd_addr1 (jmp_ra1),
      .rd_data0 (jmp_rd0),
      .rd_data1 (jmp_rd1)
   );

endmodule

@@ tb/tb_lowest_common_ancestor_unit.sv @@
// ----------------------------------------------------------------------------
// Lowest common ancestor unit testbench
// Builds trees by add words and checks every query answer against a
// binary-lifting predictor kept in step with each accepted word. A short
// directed tree comes first, then a long random spine that drives the depth
// into saturation with branches, moves and queries mixed in, then random
// queries and moves over the final forest.
// ----------------------------------------------------------------------------
module tb_lowest_common_ancestor_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_W        = lca_pkg::NODE_W;
   localparam int DEPTH_W       = lca_pkg::DEPTH_W;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = lca_pkg::DEPTH_MAX;
   localparam logic KIND_ADD    = lca_pkg::KIND_ADD;
   localparam logic KIND_QUERY  = lca_pkg::KIND_QUERY;

   localparam int NODES         = lca_pkg::MAX_NODES_DEF;
   localparam int LEVELS        = lca_pkg::LOG_LEVELS_DEF;
   localparam int SETTLE_CYCLES = 4 * LEVELS + 20;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int SPINE_STEPS   = 1030;
   localparam int FOREST_WORDS  = 60;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_kind;
   logic [NODE_W-1:0]   req_node_a;
   logic [NODE_W-1:0]   req_node_b;
   logic                rsp_valid;
   logic [NODE_W-1:0]   rsp_ancestor;

   // predictor state: depth and 2^j jumps per node
   logic [DEPTH_W-1:0]  depth_of [NODES];
   logic [NODE_W-1:0]   hop [NODES][LEVELS];
   logic [NODE_W-1:0]   ancestor_due [$];
   logic [NODE_W-1:0]   want;

   bit                  added [NODES];
   int                  added_list [$];
   int                  spine_recent [$];
   int                  tail;
   int                  burst_left;
   int                  n_adds;
   int                  n_queries;
   int                  n_checked;
   int                  err_count;
   int                  deepest;
   int                  cycle_count;

   lowest_common_ancestor_unit dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_node_a   (req_node_a),
      .req_node_b   (req_node_b),
      .rsp_valid    (rsp_valid),
      .rsp_ancestor (rsp_ancestor)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void apply_add(input logic [NODE_W-1:0] n,
                                     input logic [NODE_W-1:0] par);
      logic [DEPTH_W:0] d;
      if (n == '0) return;
      d = {1'b0, depth_of[par]} + 1'b1;
      if (d > {1'b0, DEPTH_MAX}) d = {1'b0, DEPTH_MAX};
      depth_of[n] = d[DEPTH_W-1:0];
      if (int'(d) > deepest) deepest = int'(d);
      hop[n][0] = par;
      // each level from the table as it stands, lower level first
      for (int j = 1; j < LEVELS; j++) hop[n][j] = hop[hop[n][j-1]][j-1];
   endfunction

   function automatic logic [NODE_W-1:0] predict_ancestor(input logic [NODE_W-1:0] u,
                                                          input logic [NODE_W-1:0] v);
      logic [NODE_W-1:0]  t;
      logic [DEPTH_W-1:0] diff;
      if (u == v) return u;
      if (depth_of[u] < depth_of[v]) begin
         t = u;
         u = v;
         v = t;
      end
      diff = depth_of[u] - depth_of[v];
      for (int j = LEVELS - 1; j >= 0; j--) if (diff[j]) u = hop[u][j];
      if (u == v) return u;
      for (int j = LEVELS - 1; j >= 0; j--) begin
         if (hop[u][j] != hop[v][j]) begin
            u = hop[u][j];
            v = hop[v][j];
         end
      end
      return hop[u][0];
   endfunction

   function automatic int pick_node();
      return added_list[$urandom_range(0, added_list.size() - 1)];
   endfunction

   function automatic int pick_other(input int excl);
      int x;
      do x = pick_node(); while (x == excl);
      return x;
   endfunction

   // bursts of back-to-back words, random gaps between most bursts
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 60);
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_word(input logic kind, input int a, input int b);
      pace();
      start      <= 1'b1;
      req_kind   <= kind;
      req_node_a <= NODE_W'(a);
      req_node_b <= NODE_W'(b);
      do @(posedge clock); while (busy);
      if (kind == KIND_ADD) begin
         apply_add(NODE_W'(a), NODE_W'(b));
         n_adds++;
         if (a != 0 && !added[a]) begin
            added[a] = 1'b1;
            added_list.insert(added_list.size(), a);
         end
      end else begin
         ancestor_due.insert(ancestor_due.size(),
                             predict_ancestor(NODE_W'(a), NODE_W'(b)));
         n_queries++;
      end
   endtask

   // hold off until every answer is in and the block has gone quiet
   task automatic settle();
      start <= 1'b0;
      while (ancestor_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_query_pick();
      int a;
      int b;
      int t;
      case ($urandom_range(0, 9))
         0: begin
            a = pick_node();
            b = a;
         end
         1: begin
            a = 0;
            b = pick_node();
         end
         2, 3, 4, 5: begin
            a = spine_recent[$urandom_range(0, spine_recent.size() - 1)];
            b = spine_recent[$urandom_range(0, spine_recent.size() - 1)];
         end
         default: begin
            a = pick_node();
            b = pick_node();
         end
      endcase
      if ($urandom_range(0, 1)) begin
         t = a;
         a = b;
         b = t;
      end
      send_word(KIND_QUERY, a, b);
   endtask

   // move a node under another one, or drop an add of the sentinel
   task automatic send_move(input int keep);
      if ($urandom_range(0, 7) == 0)
         send_word(KIND_ADD, 0, $urandom_range(0, NODES - 1));
      else if ($urandom_range(0, 5) == 0)
         send_word(KIND_ADD, pick_other(keep), 0);
      else
         send_word(KIND_ADD, pick_other(keep), pick_node());
   endtask

   task automatic test_directed_tree();
      send_word(KIND_ADD, 1, 0);
      send_word(KIND_ADD, 2, 1);
      send_word(KIND_ADD, 3, 1);
      send_word(KIND_ADD, 4, 2);
      send_word(KIND_ADD, 5, 4);
      send_word(KIND_ADD, 1023, 3);
      send_word(KIND_ADD, 512, 0);
      send_word(KIND_ADD, 0, 700);
      send_word(KIND_QUERY, 5, 5);
      send_word(KIND_QUERY, 5, 1023);
      send_word(KIND_QUERY, 4, 5);
      send_word(KIND_QUERY, 5, 2);
      send_word(KIND_QUERY, 1023, 512);
      send_word(KIND_QUERY, 0, 5);
      send_word(KIND_QUERY, 0, 0);
      send_word(KIND_QUERY, 1023, 0);
      // move a node with a child below it: the child keeps stale jumps
      send_word(KIND_ADD, 4, 3);
      send_word(KIND_QUERY, 5, 1023);
      send_word(KIND_QUERY, 4, 1023);
      send_word(KIND_ADD, 3, 3);
      send_word(KIND_QUERY, 1023, 2);
      send_word(KIND_ADD, 682, 1023);
      send_word(KIND_ADD, 341, 682);
      send_word(KIND_QUERY, 341, 5);
      send_word(KIND_QUERY, 341, 682);
      tail = 341;
      spine_recent.insert(spine_recent.size(), 682);
      spine_recent.insert(spine_recent.size(), 341);
   endtask

   // grow one long chain past the depth ceiling, mixing in moves and queries
   task automatic test_deep_spine();
      int fresh_ids [$];
      int steps;
      int i;
      int k;
      int t;
      int x;
      int r;
      steps = 0;
      for (i = 1; i < NODES; i++) if (!added[i]) fresh_ids.insert(fresh_ids.size(), i);
      for (i = fresh_ids.size() - 1; i > 0; i--) begin
         k = $urandom_range(0, i);
         t = fresh_ids[i];
         fresh_ids[i] = fresh_ids[k];
         fresh_ids[k] = t;
      end
      while (steps < SPINE_STEPS) begin
         r = $urandom_range(0, 99);
         if (r < 94) begin
            x = (fresh_ids.size() != 0) ? fresh_ids.pop_front() : pick_other(tail);
            send_word(KIND_ADD, x, tail);
            tail = x;
            spine_recent.insert(spine_recent.size(), x);
            if (spine_recent.size() > 48) void'(spine_recent.pop_front());
            steps++;
         end else if (r < 96) begin
            send_move(tail);
         end else begin
            send_query_pick();
         end
      end
   endtask

   task automatic test_forest_queries();
      repeat (FOREST_WORDS) begin
         if ($urandom_range(0, 3) == 0) send_move(-1);
         else send_query_pick();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (ancestor_due.size() == 0) begin
            err_count++;
            $display("%0t: answer with none expected, expected none, actual %0d",
                     $time, rsp_ancestor);
         end else begin
            want = ancestor_due.pop_front();
            n_checked++;
            if (rsp_ancestor !== want) begin
               err_count++;
               $display("%0t: ancestor mismatch, expected %0d, actual %0d",
                        $time, want, rsp_ancestor);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at cycle limit, %0d answers outstanding",
                  ancestor_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_kind    = KIND_ADD;
      req_node_a  = '0;
      req_node_b  = '0;
      burst_left  = 0;
      n_adds      = 0;
      n_queries   = 0;
      n_checked   = 0;
      err_count   = 0;
      deepest     = 0;
      cycle_count = 0;
      tail        = 0;
      for (int i = 0; i < NODES; i++) begin
         depth_of[i] = '0;
         added[i]    = 1'b0;
         for (int j = 0; j < LEVELS; j++) hop[i][j] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_tree();
      settle();
      test_deep_spine();
      settle();
      test_forest_queries();
      settle();

      $display("Covered %0d add words and %0d query words, %0d answers checked.",
               n_adds, n_queries, n_checked);
      $display("Deepest depth reached %0d of %0d, %0d nodes placed.",
               deepest, DEPTH_MAX, added_list.size());
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
